/* src/gray4fb_pkg.sv */
package gray4fb_pkg;

    // Request codes carried on the req_type field.
    localparam logic [2:0] REQ_PIXEL = 3'd0;
    localparam logic [2:0] REQ_HLINE = 3'd1;
    localparam logic [2:0] REQ_VLINE = 3'd2;
    localparam logic [2:0] REQ_CLEAR = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // Control states of the writer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PIX,
        ST_WR,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

/* src/gray4_framebuffer_writer.sv */
// Framebuffer writer for a 4-bit gray panel, two pixels packed per byte with
// the even-x pixel in the high nibble. Requests arrive on a valid/ready input
// channel (pixel, horizontal line, vertical line, clear, read byte) and each
// request returns exactly one result on a valid/ready output channel. Only
// read requests carry data; all other results are zero with is_read low.
// The rotation register is written through i_cfg_wr_en / i_cfg_wr_data and
// must only change while no request is in flight.
// The frame memory read is registered, so each on-panel pixel is a read of
// its byte in ST_PIX followed by a write of the same byte in ST_WR; an
// off-panel pixel is skipped in ST_PIX. A read request passes ST_READ, a
// clear walks every byte in ST_CLEAR, and an empty line or unused code goes
// straight to ST_DONE. The input accepts the next request in the cycle after
// the result is formed. After reset the block sweeps the memory to zero, one
// byte per cycle, with the input not ready. When the receiver stalls, the
// result waits in the output register; the next request is still accepted
// and processed, and its result waits until the output register frees up.
module gray4_framebuffer_writer #(
    parameter int PANEL_WIDTH  = 256,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [10:0] i_x_coord,
    input  logic signed [10:0] i_y_coord,
    input  logic signed [10:0] i_line_length,
    input  logic [3:0]         i_pixel_color,
    input  logic [12:0]        i_read_addr,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_read_data,
    output logic               o_is_read
);

    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 1) / 2;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic [31:0]        STORE_U  = 32'(STORE_BYTES);
    localparam logic [31:0]        WIDTH_U  = 32'(PANEL_WIDTH);
    localparam logic [AW-1:0]      LAST_IDX = AW'(STORE_BYTES - 1);
    localparam logic signed [11:0] PW       = 12'(PANEL_WIDTH);
    localparam logic signed [11:0] PH       = 12'(PANEL_HEIGHT);
    localparam logic signed [11:0] PW_M1    = 12'(PANEL_WIDTH - 1);
    localparam logic signed [11:0] PH_M1    = 12'(PANEL_HEIGHT - 1);

    // Frame memory, one write and one registered read per cycle.
    logic [7:0] mem [STORE_BYTES];
    logic [7:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic [AW-1:0] mem_ra;

    gray4fb_pkg::t_state r_state, n_state;

    logic [1:0]         r_rotation;
    logic [AW-1:0]      r_walk, n_walk;
    logic               r_clr_req, n_clr_req;
    logic               r_out_valid, n_out_valid;
    logic signed [11:0] r_lx, n_lx;
    logic signed [11:0] r_ly, n_ly;
    logic [9:0]         r_count, n_count;
    logic               r_vert, n_vert;
    logic [3:0]         r_color, n_color;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_nib_low, n_nib_low;
    logic               r_read_oob, n_read_oob;
    logic [7:0]         r_res_data, n_res_data;
    logic               r_res_is_read, n_res_is_read;
    logic [7:0]         r_read_data, n_read_data;
    logic               r_is_read, n_is_read;

    logic signed [11:0] lw, lh, px12, py12;
    logic               in_bounds, pix_ok, last_step;
    logic [31:0]        pix_idx32, rd_addr32;

    // Logical to physical mapping of the current line position.
    always_comb begin
        lw = r_rotation[0] ? PH : PW;
        lh = r_rotation[0] ? PW : PH;
        in_bounds = (r_lx >= 12'sd0) && (r_lx < lw) && (r_ly >= 12'sd0) && (r_ly < lh);
        case (r_rotation)
            2'd1: begin
                px12 = PW_M1 - r_ly;
                py12 = r_lx;
            end
            2'd2: begin
                px12 = PW_M1 - r_lx;
                py12 = PH_M1 - r_ly;
            end
            2'd3: begin
                px12 = r_ly;
                py12 = PH_M1 - r_lx;
            end
            default: begin
                px12 = r_lx;
                py12 = r_ly;
            end
        endcase
        pix_idx32 = {22'd0, px12[10:1]} + ((32'(py12[10:0]) * WIDTH_U) >> 1);
        pix_ok    = in_bounds && (pix_idx32 < STORE_U);
        rd_addr32 = 32'(i_read_addr);
        last_step = (r_count == 10'd1);
    end

    assign o_in_ready  = (r_state == gray4fb_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_is_read   = r_is_read;

    // Next state, memory controls and result handling.
    always_comb begin
        n_state       = r_state;
        n_walk        = r_walk;
        n_clr_req     = r_clr_req;
        n_out_valid   = r_out_valid;
        n_lx          = r_lx;
        n_ly          = r_ly;
        n_count       = r_count;
        n_vert        = r_vert;
        n_color       = r_color;
        n_idx         = r_idx;
        n_nib_low     = r_nib_low;
        n_read_oob    = r_read_oob;
        n_res_data    = r_res_data;
        n_res_is_read = r_res_is_read;
        n_read_data   = r_read_data;
        n_is_read     = r_is_read;
        mem_we        = 1'b0;
        mem_wa        = r_idx;
        mem_wd        = 8'd0;
        mem_ra        = rd_addr32[AW-1:0];

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            gray4fb_pkg::ST_IDLE: begin
                n_lx          = {i_x_coord[10], i_x_coord};
                n_ly          = {i_y_coord[10], i_y_coord};
                n_color       = i_pixel_color;
                n_read_oob    = (rd_addr32 >= STORE_U);
                n_res_data    = 8'd0;
                n_res_is_read = 1'b0;
                n_vert        = 1'b0;
                n_count       = 10'd1;
                if (i_in_valid) begin
                    case (i_req_type)
                        gray4fb_pkg::REQ_PIXEL: begin
                            n_state = gray4fb_pkg::ST_PIX;
                        end
                        gray4fb_pkg::REQ_HLINE, gray4fb_pkg::REQ_VLINE: begin
                            n_vert  = (i_req_type == gray4fb_pkg::REQ_VLINE);
                            n_count = i_line_length[9:0];
                            if (i_line_length > 11'sd0) begin
                                n_state = gray4fb_pkg::ST_PIX;
                            end else begin
                                n_state = gray4fb_pkg::ST_DONE;
                            end
                        end
                        gray4fb_pkg::REQ_CLEAR: begin
                            n_state   = gray4fb_pkg::ST_CLEAR;
                            n_clr_req = 1'b1;
                            n_walk    = '0;
                        end
                        gray4fb_pkg::REQ_READ: begin
                            n_state = gray4fb_pkg::ST_READ;
                        end
                        default: begin
                            n_state = gray4fb_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            gray4fb_pkg::ST_CLEAR: begin
                // Zero one byte per cycle; also serves as the power-up sweep.
                mem_we = 1'b1;
                mem_wa = r_walk;
                if (r_walk == LAST_IDX) begin
                    n_walk    = '0;
                    n_clr_req = 1'b0;
                    n_state   = r_clr_req ? gray4fb_pkg::ST_DONE : gray4fb_pkg::ST_IDLE;
                end else begin
                    n_walk = r_walk + 1'b1;
                end
            end

            gray4fb_pkg::ST_PIX: begin
                // Issue the read of the target byte, or skip an off-panel pixel.
                mem_ra    = pix_idx32[AW-1:0];
                n_idx     = pix_idx32[AW-1:0];
                n_nib_low = px12[0];
                if (pix_ok) begin
                    n_state = gray4fb_pkg::ST_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    if (r_vert) begin
                        n_ly = r_ly + 12'sd1;
                    end else begin
                        n_lx = r_lx + 12'sd1;
                    end
                    n_state = last_step ? gray4fb_pkg::ST_DONE : gray4fb_pkg::ST_PIX;
                end
            end

            gray4fb_pkg::ST_WR: begin
                // Merge the new nibble and write the byte back.
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = r_nib_low ? {r_rd_data[7:4], r_color} : {r_color, r_rd_data[3:0]};
                n_count = r_count - 1'b1;
                if (r_vert) begin
                    n_ly = r_ly + 12'sd1;
                end else begin
                    n_lx = r_lx + 12'sd1;
                end
                n_state = last_step ? gray4fb_pkg::ST_DONE : gray4fb_pkg::ST_PIX;
            end

            gray4fb_pkg::ST_READ: begin
                n_res_data    = r_read_oob ? 8'd0 : r_rd_data;
                n_res_is_read = 1'b1;
                n_state       = gray4fb_pkg::ST_DONE;
            end

            gray4fb_pkg::ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_read_data = r_res_data;
                    n_is_read   = r_res_is_read;
                    n_state     = gray4fb_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gray4fb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gray4fb_pkg::ST_CLEAR;
            r_walk      <= '0;
            r_clr_req   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rotation  <= 2'd0;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_clr_req   <= n_clr_req;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_rotation <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_lx          <= n_lx;
        r_ly          <= n_ly;
        r_count       <= n_count;
        r_vert        <= n_vert;
        r_color       <= n_color;
        r_idx         <= n_idx;
        r_nib_low     <= n_nib_low;
        r_read_oob    <= n_read_oob;
        r_res_data    <= n_res_data;
        r_res_is_read <= n_res_is_read;
        r_read_data   <= n_read_data;
        r_is_read     <= n_is_read;
    end

    // Frame memory port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

endmodule

/* bench/gray4_framebuffer_writer_tb.sv */
`timescale 1ns / 1ps

module gray4_framebuffer_writer_tb;

    localparam int PANEL_W = 256;
    localparam int PANEL_H = 64;
    localparam int STORE_BYTES = (PANEL_W * PANEL_H + 1) / 2;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_REQUESTS = 230;
    localparam logic [2:0] REQ_LAST_CODE = 3'd7;
    // Rotation per random phase, phase 0 in the low bits: 1, 2, 3, 0, 3, 1, 2, 0.
    localparam logic [15:0] PHASE_ROTATIONS =
        {2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2, 2'd1};

    typedef struct packed {
        logic [2:0]  req;
        logic [10:0] x;
        logic [10:0] y;
        logic [10:0] len;
        logic [3:0]  color;
        logic [12:0] addr;
    } t_request;

    typedef struct packed {
        logic [7:0] data;
        logic       is_read;
    } t_readback;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_wr_data = 2'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_req_type = 3'd0;
    logic [10:0] i_x_coord = 11'd0;
    logic [10:0] i_y_coord = 11'd0;
    logic [10:0] i_line_length = 11'd0;
    logic [3:0]  i_pixel_color = 4'd0;
    logic [12:0] i_read_addr = 13'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_is_read;

    // Predicted panel contents and rotation, kept in request order.
    logic [7:0]  panel_bytes [STORE_BYTES];
    logic [1:0]  fb_rotation;
    t_readback   readback_queue [$];
    t_request    request_queue [$];
    t_request    held_request;
    bit          holding_request = 1'b0;
    bit          no_idle_stretch = 1'b0;
    int          hot_addrs [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    t_readback   awaited;

    gray4_framebuffer_writer #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_line_length (i_line_length),
        .i_pixel_color (i_pixel_color),
        .i_read_addr   (i_read_addr),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_is_read     (o_is_read)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Maps a logical coordinate to a nibble index (byte * 2 + low-nibble flag),
    // or -1 when the coordinate is off the panel.
    function automatic int panel_nibble(logic [1:0] rot, int lx, int ly);
        int lw, lh, px, py, byte_idx;
        lw = rot[0] ? PANEL_H : PANEL_W;
        lh = rot[0] ? PANEL_W : PANEL_H;
        if (lx < 0 || lx >= lw || ly < 0 || ly >= lh)
            return -1;
        case (rot)
            2'd1: begin
                px = PANEL_W - 1 - ly;
                py = lx;
            end
            2'd2: begin
                px = PANEL_W - 1 - lx;
                py = PANEL_H - 1 - ly;
            end
            2'd3: begin
                px = ly;
                py = PANEL_H - 1 - lx;
            end
            default: begin
                px = lx;
                py = ly;
            end
        endcase
        byte_idx = (px / 2) + (py * PANEL_W) / 2;
        if (byte_idx >= STORE_BYTES)
            return -1;
        return byte_idx * 2 + (px % 2);
    endfunction

    function automatic void paint_nibble(int lx, int ly, logic [3:0] color);
        int nib;
        nib = panel_nibble(fb_rotation, lx, ly);
        if (nib >= 0) begin
            if (nib % 2 == 1)
                panel_bytes[nib / 2][3:0] = color;
            else
                panel_bytes[nib / 2][7:4] = color;
        end
    endfunction

    // Updates the predicted panel for one accepted request and queues its result.
    function automatic void apply_to_panel(t_request r);
        t_readback res;
        int x, y, len;
        x = $signed(r.x);
        y = $signed(r.y);
        len = $signed(r.len);
        res.data = 8'h00;
        res.is_read = 1'b0;
        case (r.req)
            gray4fb_pkg::REQ_PIXEL: paint_nibble(x, y, r.color);
            gray4fb_pkg::REQ_HLINE:
                for (int k = 0; k < len; k++) paint_nibble(x + k, y, r.color);
            gray4fb_pkg::REQ_VLINE:
                for (int k = 0; k < len; k++) paint_nibble(x, y + k, r.color);
            gray4fb_pkg::REQ_CLEAR: foreach (panel_bytes[i]) panel_bytes[i] = 8'h00;
            gray4fb_pkg::REQ_READ: begin
                res.is_read = 1'b1;
                if (r.addr < STORE_BYTES)
                    res.data = panel_bytes[r.addr];
            end
            default: ;
        endcase
        readback_queue.push_back(res);
    endfunction

    function automatic void queue_request(logic [2:0] kind, int x, int y, int len,
                                          int color, int addr);
        t_request r;
        r.req = kind;
        r.x = 11'(x);
        r.y = 11'(y);
        r.len = 11'(len);
        r.color = 4'(color);
        r.addr = 13'(addr);
        request_queue.push_back(r);
    endfunction

    // Random request, mostly near the logical panel; reads favor bytes drawn lately.
    function automatic t_request make_random_request(logic [1:0] rot);
        t_request r;
        int lw, lh, pick, v, k, nib;
        lw = rot[0] ? PANEL_H : PANEL_W;
        lh = rot[0] ? PANEL_W : PANEL_H;
        r.color = 4'($urandom_range(0, 15));
        r.addr = 13'($urandom_range(0, 8191));
        if ($urandom_range(0, 9) == 0) begin
            r.x = 11'($urandom_range(0, 2047));
        end else begin
            v = $urandom_range(0, lw + 15);
            r.x = 11'(v - 8);
        end
        if ($urandom_range(0, 9) == 0) begin
            r.y = 11'($urandom_range(0, 2047));
        end else begin
            v = $urandom_range(0, lh + 15);
            r.y = 11'(v - 8);
        end

        // Lengths are mostly short to keep line walks quick.
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            v = $urandom_range(1, 24);
        end else if (pick < 82) begin
            v = $urandom_range(0, 3);
            v = -v;
        end else if (pick < 96) begin
            v = $urandom_range(25, 300);
        end else begin
            v = $urandom_range(0, 2047);
        end
        r.len = 11'(v);

        pick = $urandom_range(0, 999);
        if (pick < 300) begin
            r.req = gray4fb_pkg::REQ_PIXEL;
        end else if (pick < 500) begin
            r.req = gray4fb_pkg::REQ_HLINE;
        end else if (pick < 650) begin
            r.req = gray4fb_pkg::REQ_VLINE;
        end else if (pick < 960) begin
            r.req = gray4fb_pkg::REQ_READ;
        end else if (pick < 985) begin
            r.req = 3'($urandom_range(gray4fb_pkg::REQ_READ + 1, REQ_LAST_CODE));
        end else if (pick < 988) begin
            r.req = gray4fb_pkg::REQ_CLEAR;
        end else begin
            r.req = gray4fb_pkg::REQ_PIXEL;
            r.x = 11'($urandom_range(0, 2047));
            r.y = 11'($urandom_range(0, 2047));
        end

        if (r.req == gray4fb_pkg::REQ_READ && hot_addrs.size() != 0 &&
            $urandom_range(0, 9) < 6)
            r.addr = 13'(hot_addrs[$urandom_range(0, hot_addrs.size() - 1)]);

        // Remember one drawn byte so that later reads can check it.
        if (r.req == gray4fb_pkg::REQ_PIXEL || r.req == gray4fb_pkg::REQ_HLINE ||
            r.req == gray4fb_pkg::REQ_VLINE) begin
            if (r.req == gray4fb_pkg::REQ_PIXEL || $signed(r.len) <= 0)
                k = 0;
            else
                k = $urandom_range(0, $signed(r.len) - 1);
            if (r.req == gray4fb_pkg::REQ_VLINE)
                nib = panel_nibble(rot, $signed(r.x), $signed(r.y) + k);
            else
                nib = panel_nibble(rot, $signed(r.x) + k, $signed(r.y));
            if (nib >= 0) begin
                hot_addrs.push_back(nib / 2);
                if (hot_addrs.size() > 32)
                    void'(hot_addrs.pop_front());
            end
        end
        return r;
    endfunction

    task automatic wait_for_drain();
        while (request_queue.size() != 0 || holding_request || readback_queue.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_rotation(input logic [1:0] rot);
        wait_for_drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= rot;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        fb_rotation = rot;
    endtask

    // Request driver: holds each request until accepted, idles at random between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_to_panel(held_request);
                holding_request = 1'b0;
            end
            if (!holding_request && request_queue.size() != 0 &&
                (no_idle_stretch || $urandom_range(0, 99) >= 25)) begin
                held_request = request_queue.pop_front();
                holding_request = 1'b1;
                i_req_type <= held_request.req;
                i_x_coord <= held_request.x;
                i_y_coord <= held_request.y;
                i_line_length <= held_request.len;
                i_pixel_color <= held_request.color;
                i_read_addr <= held_request.addr;
            end
            i_in_valid <= holding_request;
        end
    end

    // Result monitor: compares each result with the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (readback_queue.size() == 0) begin
                    $error("unexpected result: read_data %02h is_read %0b",
                           o_read_data, o_is_read);
                    mismatch_count++;
                end else begin
                    awaited = readback_queue.pop_front();
                    if (o_read_data !== awaited.data) begin
                        $error("read_data expected %02h actual %02h",
                               awaited.data, o_read_data);
                        mismatch_count++;
                    end
                    if (o_is_read !== awaited.is_read) begin
                        $error("is_read expected %0b actual %0b",
                               awaited.is_read, o_is_read);
                        mismatch_count++;
                    end
                end
            end
            i_out_ready <= no_idle_stretch || ($urandom_range(0, 99) >= 25);
        end
    end

    // Watchdog on cycles in which neither channel moves a request or a result.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("gray4_framebuffer_writer: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_request r;
        foreach (panel_bytes[i]) panel_bytes[i] = 8'h00;
        fb_rotation = 2'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_rotation(2'd0);

        // Directed requests: field extremes, clipping, empty lines and unused codes.
        queue_request(gray4fb_pkg::REQ_READ, 0, 0, 0, 0, 0);
        queue_request(gray4fb_pkg::REQ_PIXEL, 0, 0, 0, 15, 0);
        queue_request(gray4fb_pkg::REQ_READ, 0, 0, 0, 0, 0);
        queue_request(gray4fb_pkg::REQ_PIXEL, 255, 63, 0, 5, 0);
        queue_request(gray4fb_pkg::REQ_READ, 0, 0, 0, 0, 8191);
        queue_request(gray4fb_pkg::REQ_PIXEL, -1, 5, 0, 7, 0);
        queue_request(gray4fb_pkg::REQ_PIXEL, 256, 5, 0, 7, 0);
        queue_request(gray4fb_pkg::REQ_PIXEL, 3, 64, 0, 7, 0);
        queue_request(gray4fb_pkg::REQ_PIXEL, -1024, 1023, 0, 15, 0);
        queue_request(gray4fb_pkg::REQ_PIXEL, 1023, -1024, 0, 15, 0);
        queue_request(gray4fb_pkg::REQ_HLINE, -3, 1, 10, 9, 0);
        queue_request(gray4fb_pkg::REQ_READ, 0, 0, 0, 0, 128);
        queue_request(gray4fb_pkg::REQ_HLINE, 250, 2, 1023, 12, 0);
        queue_request(gray4fb_pkg::REQ_READ, 0, 0, 0, 0, 383);
        queue_request(gray4fb_pkg::REQ_HLINE, 0, 3, 0, 15, 0);
        queue_request(gray4fb_pkg::REQ_HLINE, 0, 3, -1024, 15, 0);
        queue_request(gray4fb_pkg::REQ_VLINE, 7, 60, 1023, 3, 0);
        queue_request(gray4fb_pkg::REQ_READ, 0, 0, 0, 0, 8067);
        queue_request(gray4fb_pkg::REQ_VLINE, 8, -5, -1, 6, 0);
        queue_request(gray4fb_pkg::REQ_READ + 1, 1023, 1023, 1023, 15, 8191);
        queue_request(gray4fb_pkg::REQ_READ + 2, -1024, -1024, -1024, 0, 0);
        queue_request(REQ_LAST_CODE, 5, 5, 5, 10, 4097);
        queue_request(gray4fb_pkg::REQ_READ, 0, 0, 0, 0, 384);
        queue_request(gray4fb_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
        queue_request(gray4fb_pkg::REQ_READ, 0, 0, 0, 0, 0);

        // Random phases, one rotation each; one phase runs with no idling.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_rotation(PHASE_ROTATIONS[2 * p +: 2]);
            no_idle_stretch = (p == 3);
            for (int n = 0; n < PHASE_REQUESTS; ) begin
                r = make_random_request(PHASE_ROTATIONS[2 * p +: 2]);
                request_queue.push_back(r);
                if (r.req <= gray4fb_pkg::REQ_READ)
                    n++;
            end
        end

        wait_for_drain();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("gray4_framebuffer_writer: match");
        end else begin
            $display("gray4_framebuffer_writer: mismatch");
        end
        $finish;
    end

endmodule
